>>> design/cptq_pkg.sv
// shared widths, operation codes and status codes of the path clearance table
package cptq_pkg;

  localparam int FIELD_W  = 16;   // distances, clearances, path indexes
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int DPC_W    = 7;    // decimated path count register
  localparam int MAP_W    = 24;   // 2*k*(D-1) + (A-1) always fits
  localparam int DIV_DW   = 17;   // divisor width: 2*(A-1) or a sample count
  localparam int CFG_IDX_W = 1;

  localparam int MAX_PATHS_DEF   = 64;
  localparam int MAX_SAMPLES_DEF = 64;

  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_RISING = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTUAL_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIMATED_COUNT = 1'b1;

endpackage

>>> design/cptq_if.sv
// valid/ready channel interfaces for operation items and result items
interface cptq_in_if
  import cptq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [FIELD_W-1:0]  path_index;
  logic [FIELD_W-1:0]  distance;
  logic [FIELD_W-1:0]  clearance;
  logic                use_mean;

  modport source (output valid, mode, path_index, distance, clearance, use_mean,
                  input ready);
  modport sink   (input valid, mode, path_index, distance, clearance, use_mean,
                  output ready);
endinterface

interface cptq_out_if
  import cptq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [FIELD_W-1:0]  clearance_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, clearance_out, status, input ready);
  modport sink   (input valid, clearance_out, status, output ready);
endinterface

>>> design/cptq_ram.sv
// simple dual-port synchronous ram, one write and one registered read per cycle
module cptq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/cptq_div.sv
// restoring divider, one quotient bit per cycle, shared by index mapping and mean
module cptq_div #(
  parameter int NW = 27,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DW:0]      shifted;
  logic             ge;

  assign shifted = {rem_r, quo_r[NW-1]};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? DW'(shifted - {1'b0, dvs_r}) : shifted[DW-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> design/path_clearance_table_query.sv
// path clearance table: per-path sample lists with append, clear and query
//
// Items arrive on in_item (valid/ready) and each one yields exactly one result
// on out_item. One item is worked on at a time: in_item.ready is high only
// while the block is idle, and the result sits in an output register until
// out_item.ready takes it, so a stalled receiver simply holds the block.
// Operations: query (mode 0), append sample (mode 1), clear all lists (mode 2).
// Steps per operation, with DNW = max(24, 16 + clog2(MAX_SAMPLES+1)) the
// divider width: a query reads the list's count, then visits its samples
// through the one-read-per-cycle sample memory; the shared bit-serial
// divider of DNW bits scales the path index first when needed and forms a
// mean at the end. An empty list skips the walk; a flagged query, or one
// while the table is unused, goes straight to the result. An append reads
// the count, reads the last sample and writes back; a full list stops after
// the count read and a bad index goes straight to the result. A clear zeroes
// one count entry per cycle. The next item is taken only after the result has been transferred.
// After reset the block zeroes every entry of the count memory before
// taking its first item; configuration writes on cfg_we/cfg_index/cfg_wdata
// are taken at any time and should only be issued while the block is idle.
module path_clearance_table_query
  import cptq_pkg::*;
#(
  parameter int MAX_PATHS   = MAX_PATHS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_wdata,
  cptq_in_if.sink              in_item,
  cptq_out_if.source           out_item
);

  localparam int PW    = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int SW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int DEPTH = MAX_PATHS * MAX_SAMPLES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = FIELD_W + CW;
  localparam int DNW   = (SUM_W > MAP_W) ? SUM_W : MAP_W;

  typedef enum logic [10:0] {
    S_INIT = 11'b00000000001,
    S_IDLE = 11'b00000000010,
    S_MAP  = 11'b00000000100,
    S_CRD  = 11'b00000001000,
    S_CNT  = 11'b00000010000,
    S_WALK = 11'b00000100000,
    S_MEAN = 11'b00001000000,
    S_ARD  = 11'b00010000000,
    S_ACHK = 11'b00100000000,
    S_CLR  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [FIELD_W-1:0] apc_r;
  logic [DPC_W-1:0]   dpc_r;
  logic [DPC_W-1:0]   de;
  logic [FIELD_W-1:0] a1;

  // item in flight
  logic [MODE_W-1:0]   mode_r,  mode_nxt;
  logic [FIELD_W-1:0]  dist_r,  dist_nxt;
  logic [FIELD_W-1:0]  clr_r,   clr_nxt;
  logic                mean_r,  mean_nxt;
  logic [PW-1:0]       p_r,     p_nxt;
  logic [AW-1:0]       base_r,  base_nxt;
  logic [CW-1:0]       n_r,     n_nxt;
  logic [CW-1:0]       rd_j_r,  rd_j_nxt;
  logic                vld_r,   vld_nxt;
  logic [CW-1:0]       cnt_r,   cnt_nxt;
  logic [SUM_W-1:0]    sum_r,   sum_nxt;
  logic [FIELD_W-1:0]  res_r,   res_nxt;
  logic [STATUS_W-1:0] st_r,    st_nxt;
  logic [PW-1:0]       swp_r,   swp_nxt;

  // memories
  logic             sweep;
  logic             cnt_we;
  logic [PW-1:0]    cnt_waddr;
  logic [CW-1:0]    cnt_wdata;
  logic [CW-1:0]    cnt_rdata;
  logic             st_we;
  logic [AW-1:0]    st_waddr;
  logic [AW-1:0]    st_raddr;
  logic [31:0]      st_rdata;

  // divider
  logic             div_start;
  logic [DNW-1:0]   div_dvd;
  logic [DIV_DW-1:0] div_dvs;
  logic             div_busy;
  logic             div_done;
  logic [DNW-1:0]   div_q;

  logic [MAP_W-1:0] map_num;
  logic [SUM_W-1:0] sum_inc;
  logic [CW-1:0]    cnt_inc;
  logic             in_xfer;
  logic             append_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apc_r <= '0;
      dpc_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTUAL_COUNT:    apc_r <= cfg_wdata;
        CFG_DECIMATED_COUNT: dpc_r <= cfg_wdata[DPC_W-1:0];
        default: ;
      endcase
    end
  end

  // decimated count saturates at the table size
  assign de = (int'(dpc_r) > MAX_PATHS) ? DPC_W'(MAX_PATHS) : dpc_r;
  assign a1 = apc_r - FIELD_W'(1);

  // round(k*(D-1)/(A-1)) as floor((2*k*(D-1) + (A-1)) / (2*(A-1)))
  assign map_num = MAP_W'({in_item.path_index, 1'b0}) * MAP_W'(de - DPC_W'(1))
                 + MAP_W'(a1);
  assign sum_inc = sum_r + SUM_W'(st_rdata[FIELD_W-1:0]);
  assign cnt_inc = cnt_r + CW'(1);

  assign in_xfer   = in_item.valid && in_item.ready;
  assign sweep     = (state_r == S_INIT) || (state_r == S_CLR);
  assign append_ok = (n_r == '0) || (dist_r > st_rdata[31:FIELD_W]);

  assign div_dvd = (state_r == S_IDLE) ? DNW'(map_num) : DNW'(sum_inc);
  assign div_dvs = (state_r == S_IDLE) ? {a1, 1'b0} : DIV_DW'(cnt_inc);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    dist_nxt  = dist_r;
    clr_nxt   = clr_r;
    mean_nxt  = mean_r;
    p_nxt     = p_r;
    base_nxt  = base_r;
    n_nxt     = n_r;
    rd_j_nxt  = rd_j_r;
    vld_nxt   = 1'b0;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    swp_nxt   = swp_r;
    div_start = 1'b0;
    st_we     = 1'b0;

    case (state_r)
      S_INIT, S_CLR: begin
        swp_nxt = swp_r + PW'(1);
        if (swp_r == PW'(MAX_PATHS - 1)) begin
          swp_nxt   = '0;
          state_nxt = (state_r == S_CLR) ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          mode_nxt = in_item.mode;
          dist_nxt = in_item.distance;
          clr_nxt  = in_item.clearance;
          mean_nxt = in_item.use_mean;
          res_nxt  = '0;
          st_nxt   = ST_OK;
          p_nxt    = '0;
          case (in_item.mode)
            MODE_QUERY: begin
              if (de == '0) begin
                state_nxt = S_OUT;
              end else if (in_item.path_index >= apc_r) begin
                st_nxt    = ST_BAD_INDEX;
                state_nxt = S_OUT;
              end else if (apc_r <= FIELD_W'(1) || de <= DPC_W'(1)) begin
                state_nxt = S_CRD;
              end else begin
                div_start = 1'b1;
                state_nxt = S_MAP;
              end
            end
            MODE_APPEND: begin
              if (in_item.path_index >= FIELD_W'(de)) begin
                st_nxt    = ST_BAD_INDEX;
                state_nxt = S_OUT;
              end else begin
                p_nxt     = PW'(in_item.path_index);
                state_nxt = S_CRD;
              end
            end
            MODE_CLEAR: begin
              swp_nxt   = '0;
              state_nxt = S_CLR;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_MAP: begin
        if (div_done) begin
          p_nxt     = (div_q >= DNW'(de)) ? PW'(de - DPC_W'(1)) : PW'(div_q);
          state_nxt = S_CRD;
        end
      end
      S_CRD: begin
        // count memory is reading entry p_r during this cycle
        base_nxt  = AW'(p_r * MAX_SAMPLES);
        state_nxt = S_CNT;
      end
      S_CNT: begin
        n_nxt = cnt_rdata;
        if (mode_r == MODE_QUERY) begin
          if (cnt_rdata == '0) begin
            state_nxt = S_OUT;
          end else begin
            rd_j_nxt  = '0;
            cnt_nxt   = '0;
            sum_nxt   = '0;
            state_nxt = S_WALK;
          end
        end else if (int'(cnt_rdata) >= MAX_SAMPLES) begin
          st_nxt    = ST_FULL;
          state_nxt = S_OUT;
        end else begin
          // fetch the last sample; an empty list reads a don't-care entry
          rd_j_nxt  = cnt_rdata - CW'(1);
          state_nxt = S_ARD;
        end
      end
      S_WALK: begin
        // one sample read issued per cycle, processed in the following cycle
        if (rd_j_r < n_r) begin
          rd_j_nxt = rd_j_r + CW'(1);
          vld_nxt  = 1'b1;
        end
        if (vld_r) begin
          sum_nxt = sum_inc;
          cnt_nxt = cnt_inc;
          if ((st_rdata[31:FIELD_W] > dist_r) || (cnt_inc == n_r)) begin
            vld_nxt = 1'b0;
            if (mean_r) begin
              div_start = 1'b1;
              state_nxt = S_MEAN;
            end else begin
              res_nxt   = st_rdata[FIELD_W-1:0];
              state_nxt = S_OUT;
            end
          end
        end
      end
      S_MEAN: begin
        if (div_done) begin
          res_nxt   = div_q[FIELD_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_ARD: begin
        state_nxt = S_ACHK;
      end
      S_ACHK: begin
        if (append_ok) begin
          st_we = 1'b1;
        end else begin
          st_nxt = ST_NOT_RISING;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_item.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      swp_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      swp_r   <= swp_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    dist_r <= dist_nxt;
    clr_r  <= clr_nxt;
    mean_r <= mean_nxt;
    p_r    <= p_nxt;
    base_r <= base_nxt;
    n_r    <= n_nxt;
    rd_j_r <= rd_j_nxt;
    cnt_r  <= cnt_nxt;
    sum_r  <= sum_nxt;
    res_r  <= res_nxt;
    st_r   <= st_nxt;
  end

  assign cnt_we    = sweep || st_we;
  assign cnt_waddr = sweep ? swp_r : p_r;
  assign cnt_wdata = sweep ? '0 : (n_r + CW'(1));

  assign st_raddr = base_r + AW'(rd_j_r[SW-1:0]);
  assign st_waddr = base_r + AW'(n_r[SW-1:0]);

  cptq_ram #(
    .DEPTH (MAX_PATHS),
    .WIDTH (CW),
    .AW    (PW)
  ) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (p_r),
    .rdata (cnt_rdata)
  );

  cptq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (32),
    .AW    (AW)
  ) u_samples (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata ({dist_r, clr_r}),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  cptq_div #(
    .NW (DNW),
    .DW (DIV_DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_item.ready          = (state_r == S_IDLE);
  assign out_item.valid         = (state_r == S_OUT);
  assign out_item.clearance_out = res_r;
  assign out_item.status        = st_r;

  // one item at a time: an accepted item closes the input for the next cycle
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_item.ready)
    else $error("input taken while an item is in flight");

  // flagged results carry no clearance
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && out_item.status != ST_OK) |-> (out_item.clearance_out == '0))
    else $error("flagged result with nonzero clearance");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // an append never grows a list beyond its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_we && !sweep) |-> (int'(n_r) < MAX_SAMPLES))
    else $error("sample count overflow");

endmodule

>>> dv/testbench.sv
// self-checking testbench for the path clearance table: directed and random operation streams
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cptq_pkg::*;

  localparam int NPATH = MAX_PATHS_DEF;
  localparam int NSAMP = MAX_SAMPLES_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 800000;
  localparam int LONG_STALL = 400;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_REPORTS = 10;
  localparam int NPHASE = 10;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] path_index;
    logic [FIELD_W-1:0] distance;
    logic [FIELD_W-1:0] clearance;
    logic               use_mean;
  } table_op_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  clearance_out;
    logic [STATUS_W-1:0] status;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0] cfg_wdata;

  cptq_in_if  in_bus ();
  cptq_out_if out_bus ();

  path_clearance_table_query uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_item  (in_bus),
    .out_item (out_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted table contents and registers
  logic [FIELD_W-1:0] path_dist [NPATH][NSAMP];
  logic [FIELD_W-1:0] path_clr  [NPATH][NSAMP];
  int                 path_len  [NPATH];
  logic [FIELD_W-1:0] actual_count;
  logic [DPC_W-1:0]   decimated_count;

  // generator-side view of the lists, used to build rising sample sequences
  int gen_top [NPATH];
  int gen_len [NPATH];
  int gen_actual;
  int gen_paths;

  table_op_t    pending_ops[$];
  table_reply_t expected_replies[$];
  int ops_queued = 0;
  int ops_accepted = 0;
  int error_count = 0;
  int cycle_count = 0;
  int long_stall_req = 0;

  int phase_actual [NPHASE] = '{1, 64, 65535, 100, 37, 0, 300, 2, 65535, 1000};
  int phase_decim  [NPHASE] = '{64, 64, 64, 127, 1, 10, 0, 40, 100, 2};

  function automatic table_reply_t apply_table_op(table_op_t op);
    table_reply_t r;
    int de, p, n, j, k;
    longint a1, num, sum;
    logic [FIELD_W-1:0] last;
    bit stop;
    r.clearance_out = '0;
    r.status = ST_OK;
    de = (decimated_count > NPATH) ? NPATH : int'(decimated_count);
    k = int'(op.path_index);
    case (op.mode)
      MODE_QUERY: begin
        if (de == 0) begin
          r.status = ST_OK;
        end else if (k >= actual_count) begin
          r.status = ST_BAD_INDEX;
        end else begin
          if (actual_count <= 1 || de <= 1) begin
            p = 0;
          end else begin
            // round(k*(de-1)/(A-1)) with halves going up
            a1 = longint'(actual_count) - 1;
            num = 2 * longint'(k) * (de - 1) + a1;
            p = int'(num / (2 * a1));
          end
          if (p >= de) p = de - 1;
          n = path_len[p];
          sum = 0;
          last = '0;
          stop = 1'b0;
          // visit up to and including the first sample beyond the query distance
          for (j = 0; j < n && !stop; j++) begin
            last = path_clr[p][j];
            sum += last;
            stop = path_dist[p][j] > op.distance;
          end
          if (n > 0) r.clearance_out = op.use_mean ? FIELD_W'(sum / j) : last;
        end
      end
      MODE_APPEND: begin
        if (k >= de) begin
          r.status = ST_BAD_INDEX;
        end else if (path_len[k] >= NSAMP) begin
          r.status = ST_FULL;
        end else if (path_len[k] > 0 && op.distance <= path_dist[k][path_len[k] - 1]) begin
          r.status = ST_NOT_RISING;
        end else begin
          path_dist[k][path_len[k]] = op.distance;
          path_clr[k][path_len[k]] = op.clearance;
          path_len[k]++;
        end
      end
      MODE_CLEAR: begin
        foreach (path_len[i]) path_len[i] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void queue_op(logic [MODE_W-1:0] mode, int idx, int sample_dist, int clr,
                                   bit mean);
    table_op_t op;
    op.mode = mode;
    op.path_index = FIELD_W'(idx);
    op.distance = FIELD_W'(sample_dist);
    op.clearance = FIELD_W'(clr);
    op.use_mean = mean;
    if (mode == MODE_APPEND && idx >= 0 && idx < gen_paths && gen_len[idx] < NSAMP &&
        sample_dist > gen_top[idx]) begin
      gen_top[idx] = sample_dist;
      gen_len[idx]++;
    end else if (mode == MODE_CLEAR) begin
      foreach (gen_len[i]) begin
        gen_len[i] = 0;
        gen_top[i] = -1;
      end
    end
    pending_ops.push_back(op);
    ops_queued++;
  endfunction

  function automatic int pick_query_index();
    if (gen_actual == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, gen_actual - 1);
  endfunction

  function automatic int pick_query_dist();
    if ($urandom_range(0, 1)) return $urandom_range(0, 65535);
    return $urandom_range(0, 65535 >> $urandom_range(0, 6));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= FIELD_W'(value);
    if (idx == CFG_ACTUAL_COUNT) actual_count = FIELD_W'(value);
    else decimated_count = DPC_W'(value);
  endtask

  task automatic set_config(int a, int d);
    write_reg(CFG_ACTUAL_COUNT, a);
    write_reg(CFG_DECIMATED_COUNT, d);
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_actual = a;
    gen_paths = (d > NPATH) ? NPATH : d;
  endtask

  // clear, then append past the list capacity, then query the full list
  task automatic fill_path(int p, int k);
    int d;
    queue_op(MODE_CLEAR, 0, 0, 0, 1'b0);
    d = $urandom_range(0, 255);
    repeat (NSAMP + 2) begin
      queue_op(MODE_APPEND, p, d, $urandom_range(0, 65535), 1'b0);
      d += $urandom_range(1, 900);
    end
    queue_op(MODE_QUERY, k, 65535, 0, 1'b1);
    queue_op(MODE_QUERY, k, 65535, 0, 1'b0);
    queue_op(MODE_QUERY, k, d / 2, 0, 1'b1);
  endtask

  task automatic random_phase(int n_ops);
    int r, p, d;
    queue_op(MODE_QUERY, 65535, 65535, 0, 1'b1);
    repeat (n_ops) begin
      r = $urandom_range(0, 99);
      p = (gen_paths > 0) ? $urandom_range(0, gen_paths - 1) : 0;
      if (r < 42) begin
        d = gen_top[p] + $urandom_range(1, 1500);
        if (d > 65535) d = 65535;
        queue_op(MODE_APPEND, p, d, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
      end else if (r < 80) begin
        queue_op(MODE_QUERY, pick_query_index(), pick_query_dist(), $urandom_range(0, 65535),
                 1'($urandom_range(0, 1)));
      end else if (r < 87) begin
        // repeated or arbitrary distance, mostly out of order
        d = ($urandom_range(0, 1) && gen_top[p] >= 0) ? gen_top[p] : $urandom_range(0, 65535);
        queue_op(MODE_APPEND, p, d, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
      end else if (r < 90) begin
        queue_op(MODE_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
      end else if (r < 94) begin
        queue_op(MODE_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
      end else begin
        queue_op(MODE_APPEND, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (ops_accepted != ops_queued || expected_replies.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // driver: bursts of transfers separated by random gaps
  table_op_t active_op;
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_replies.push_back(apply_table_op(active_op));
        ops_accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else begin
          active_op = pending_ops.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.mode <= active_op.mode;
          in_bus.path_index <= active_op.path_index;
          in_bus.distance <= active_op.distance;
          in_bus.clearance <= active_op.clearance;
          in_bus.use_mean <= active_op.use_mean;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // monitor: checks each result transfer and drives a stall pattern on ready
  table_reply_t want;
  logic [31:0] stall_pattern = '1;
  int pattern_pos = 0;
  int hold_left = 0;
  int stall_seen = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_replies.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: clearance %h status %0d",
                     out_bus.clearance_out, out_bus.status);
        end else begin
          want = expected_replies.pop_front();
          if (out_bus.clearance_out !== want.clearance_out || out_bus.status !== want.status)
          begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("mismatch: clearance exp %h got %h, status exp %0d got %0d",
                       want.clearance_out, out_bus.clearance_out, want.status, out_bus.status);
          end
        end
      end
      if (stall_seen != long_stall_req) begin
        stall_seen = long_stall_req;
        hold_left = LONG_STALL;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        pattern_pos++;
        if (pattern_pos == 32) begin
          pattern_pos = 0;
          case ($urandom_range(0, 3))
            0: stall_pattern = '1;
            1: stall_pattern = $urandom;
            2: stall_pattern = $urandom | $urandom;
            default: stall_pattern = ($urandom & $urandom) | 32'h1;
          endcase
        end
        out_bus.ready <= stall_pattern[pattern_pos];
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int ph;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ACTUAL_COUNT;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_QUERY;
    in_bus.path_index = '0;
    in_bus.distance = '0;
    in_bus.clearance = '0;
    in_bus.use_mean = 1'b0;
    out_bus.ready = 1'b0;
    actual_count = '0;
    decimated_count = '0;
    gen_actual = 0;
    gen_paths = 0;
    foreach (path_len[i]) begin
      path_len[i] = 0;
      gen_len[i] = 0;
      gen_top[i] = -1;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // registers still at reset: table unused
    queue_op(MODE_QUERY, 0, 16'h0100, 0, 1'b1);
    queue_op(MODE_APPEND, 0, 16'h0100, 16'h0200, 1'b0);
    queue_op(MODE_UNUSED, 16'hffff, 16'hffff, 16'hffff, 1'b1);
    wait_idle();

    set_config(5, 3);
    queue_op(MODE_APPEND, 0, 16'h0100, 16'h0200, 1'b0);
    queue_op(MODE_APPEND, 0, 16'h0100, 16'h1234, 1'b0);
    queue_op(MODE_APPEND, 0, 16'h00ff, 16'h1234, 1'b1);
    queue_op(MODE_APPEND, 0, 16'h0800, 16'h0000, 1'b0);
    queue_op(MODE_APPEND, 0, 16'hffff, 16'hffff, 1'b0);
    queue_op(MODE_APPEND, 3, 16'h0900, 16'h0001, 1'b0);
    queue_op(MODE_APPEND, 16'hffff, 16'h0900, 16'h0001, 1'b0);
    queue_op(MODE_APPEND, 2, 16'h0000, 16'h00ff, 1'b0);
    queue_op(MODE_APPEND, 2, 16'h0001, 16'hff00, 1'b0);
    queue_op(MODE_QUERY, 0, 16'h0000, 16'hffff, 1'b0);
    queue_op(MODE_QUERY, 0, 16'h0800, 0, 1'b1);
    queue_op(MODE_QUERY, 0, 16'hffff, 0, 1'b0);
    queue_op(MODE_QUERY, 4, 16'h0000, 0, 1'b1);
    queue_op(MODE_QUERY, 3, 16'hffff, 0, 1'b1);
    queue_op(MODE_QUERY, 2, 16'h0100, 0, 1'b1);
    queue_op(MODE_QUERY, 5, 16'h0100, 0, 1'b0);
    queue_op(MODE_QUERY, 16'hffff, 16'h0100, 0, 1'b1);
    queue_op(MODE_CLEAR, 0, 0, 0, 1'b0);
    queue_op(MODE_QUERY, 0, 16'hffff, 0, 1'b1);
    queue_op(MODE_APPEND, 0, 16'h0000, 16'h8000, 1'b0);
    queue_op(MODE_QUERY, 0, 16'h0000, 0, 1'b1);
    wait_idle();

    for (ph = 0; ph < NPHASE; ph++) begin
      set_config(phase_actual[ph], phase_decim[ph]);
      if (ph == 1) fill_path(17, 17);
      if (ph == 7) fill_path(39, 1);
      random_phase(60);
      // hold the receiver while the sender keeps offering items
      if (ph == 1) long_stall_req++;
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/cptq_pkg.sv
design/cptq_if.sv
design/cptq_ram.sv
design/cptq_div.sv
design/path_clearance_table_query.sv
dv/testbench.sv
